// File: design/mm2_pkg.sv
// shared types, constants and helpers of the murmur2 stream hasher
// no dependencies
package mm2_pkg;

  localparam logic [31:0] MUL_K = 32'h5BD1E995;

  localparam int SH_WORD = 24;
  localparam int SH_M0A  = 13;
  localparam int SH_M0B  = 15;
  localparam int SH_M1A  = 18;
  localparam int SH_M1B  = 22;
  localparam int SH_M1C  = 17;
  localparam int SH_M1D  = 19;

  localparam int IN_TDATA_W = 72;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  typedef struct packed {
    logic        mode;
    logic        first;
    logic        last;
    kind_t       kind;
    logic [2:0]  cnt;
    logic [30:0] len;
    logic [31:0] init;
    logic [31:0] word;
  } item_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] mul_k(input logic [31:0] a);
    return a * MUL_K;
  endfunction

endpackage

// File: design/mm2_front.sv
// front end: accepts stream items, classifies them and premixes full words
// depends on mm2_pkg
module mm2_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [31:0]                      seed,
  input  logic                             hash_mode,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // data_word[31:0], byte_count[34:32], msg_length[65:35], zero fill
  input  logic [mm2_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  output logic                             item_valid,
  input  logic                             item_ready,
  output mm2_pkg::item_t                   item
);
  import mm2_pkg::*;

  logic        accept;
  logic        en;
  logic [31:0] data;
  logic [2:0]  bc;
  logic [2:0]  cnt;
  logic [30:0] ml;
  kind_t       kind;
  logic [31:0] mask;
  logic [31:0] w;
  logic [31:0] x;
  logic        in_msg;
  logic        v1;
  logic        v2;
  item_t       s1;
  item_t       s1_mixed;
  item_t       s2;
  logic [31:0] p1;

  assign en       = !v2 || item_ready;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  assign data = s_tdata[31:0];
  assign bc   = s_tdata[34:32];
  assign ml   = s_tdata[65:35];
  assign cnt  = (bc > 3'd4) ? 3'd4 : bc;

  always_comb begin
    case (cnt)
      3'd0:    kind = KIND_NONE;
      3'd4:    kind = KIND_FULL;
      default: kind = KIND_TAIL;
    endcase
    case (cnt)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    if (kind == KIND_FULL) begin
      w = hash_mode ? swap_bytes(data) : data;
    end else begin
      w = data & mask;
    end
  end

  assign x = p1 ^ (p1 >> SH_WORD);

  always_comb begin
    s1_mixed = s1;
    if (s1.kind == KIND_FULL) begin
      s1_mixed.word = mul_k(x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      in_msg <= 1'b0;
    end else begin
      if (accept) begin
        in_msg <= !s_tlast;
      end
      if (en) begin
        v1 <= accept;
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.mode  <= hash_mode;
      s1.first <= !in_msg;
      s1.last  <= s_tlast;
      s1.kind  <= kind;
      s1.cnt   <= cnt;
      s1.len   <= ml;
      s1.init  <= seed ^ {1'b0, ml};
      s1.word  <= w;
      p1       <= mul_k(w);
      s2       <= s1_mixed;
    end
  end

  assign item_valid = v2;
  assign item       = s2;

endmodule

// File: design/mm2_fifo.sv
// short register queue between front and back end
// depends on mm2_pkg
module mm2_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mm2_pkg::item_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mm2_pkg::item_t out_data
);
  import mm2_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

// File: design/mm2_back.sv
// back end: hash state update per item and final avalanche with result register
// depends on mm2_pkg
module mm2_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  mm2_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  // hash_value[63:0]
  output logic [63:0]    m_tdata,
  // length_mismatch[0]
  output logic [0:0]     m_tuser
);
  import mm2_pkg::*;

  typedef enum logic [5:0] {
    ST_RUN = 6'b000001,
    ST_M0  = 6'b000010,
    ST_M1  = 6'b000100,
    ST_M2  = 6'b001000,
    ST_M3  = 6'b010000,
    ST_M4  = 6'b100000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [31:0] h1;
  logic [31:0] h1_next;
  logic [31:0] h2;
  logic [31:0] h2_next;
  logic        parity;
  logic        parity_next;
  logic [31:0] bytes_seen;
  logic [31:0] bytes_next;
  logic [30:0] len;
  logic [30:0] len_next;
  logic        mism;
  logic        mism_next;
  logic        o_valid;
  logic [63:0] o_hash;
  logic [63:0] o_hash_next;
  logic        o_load;
  logic        o_free;
  logic        pop;
  logic [31:0] b1;
  logic [31:0] b2;
  logic [31:0] base;
  logic        par;
  logic        to_second;
  logic [32:0] sum;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] upd;

  assign o_free  = !o_valid || m_tready;
  assign q_ready = state == ST_RUN;
  assign pop     = q_valid && q_ready;
  assign prod    = mul_k(mul_a);

  always_comb begin
    b1        = q_item.first ? q_item.init : h1;
    b2        = q_item.first ? 32'd0 : h2;
    par       = q_item.first ? 1'b0 : parity;
    to_second = q_item.mode && ((q_item.kind == KIND_TAIL) ||
                                ((q_item.kind == KIND_FULL) && par));
    base      = to_second ? b2 : b1;
    sum       = {1'b0, (q_item.first ? 32'd0 : bytes_seen)} + 33'(q_item.cnt);
    upd       = (q_item.kind == KIND_FULL) ? (prod ^ q_item.word) : prod;

    state_next  = state;
    h1_next     = h1;
    h2_next     = h2;
    parity_next = parity;
    bytes_next  = bytes_seen;
    len_next    = len;
    mism_next   = mism;
    o_load      = 1'b0;
    o_hash_next = o_hash;
    mul_a       = base;

    case (state)
      ST_RUN: begin
        mul_a = (q_item.kind == KIND_TAIL) ? (base ^ q_item.word) : base;
        if (pop) begin
          h1_next     = b1;
          h2_next     = b2;
          parity_next = par ^ (q_item.mode && (q_item.kind == KIND_FULL));
          bytes_next  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          len_next    = q_item.first ? q_item.len : len;
          mism_next   = bytes_next != {1'b0, len_next};
          if (q_item.kind != KIND_NONE) begin
            if (to_second) begin
              h2_next = upd;
            end else begin
              h1_next = upd;
            end
          end
          if (q_item.last) begin
            state_next = q_item.mode ? ST_M1 : ST_M0;
          end
        end
      end
      ST_M0: begin
        mul_a       = h1 ^ (h1 >> SH_M0A);
        o_hash_next = {32'd0, prod ^ (prod >> SH_M0B)};
        if (o_free) begin
          o_load     = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_M1: begin
        mul_a      = h1 ^ (h2 >> SH_M1A);
        h1_next    = prod;
        state_next = ST_M2;
      end
      ST_M2: begin
        mul_a      = h2 ^ (h1 >> SH_M1B);
        h2_next    = prod;
        state_next = ST_M3;
      end
      ST_M3: begin
        mul_a      = h1 ^ (h2 >> SH_M1C);
        h1_next    = prod;
        state_next = ST_M4;
      end
      ST_M4: begin
        mul_a       = h2 ^ (h1 >> SH_M1D);
        o_hash_next = {h1, prod};
        if (o_free) begin
          o_load     = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h1         <= h1_next;
    h2         <= h2_next;
    parity     <= parity_next;
    bytes_seen <= bytes_next;
    len        <= len_next;
    mism       <= mism_next;
    if (o_load) begin
      o_hash     <= o_hash_next;
      m_tuser[0] <= mism;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_hash;

  a_last_finishes: assert property (@(posedge clk) disable iff (rst)
    pop && q_item.last |=> state != ST_RUN)
    else $error("last item did not start the final mix");

  a_mix_chain: assert property (@(posedge clk) disable iff (rst)
    state == ST_M1 |=> state == ST_M2)
    else $error("final mix sequence broken");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_M0 || state == ST_M4) && o_valid && !m_tready |=> state == $past(state))
    else $error("result overwritten while waiting");

endmodule

// File: design/murmur2_stream_hasher.sv
// top level of the murmur2 stream hasher: config registers, front, queue, back
// depends on mm2_pkg, mm2_front, mm2_fifo, mm2_back
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata (word, count, length), s_tlast
// m_*       out        m_tvalid/m_tready  m_tdata (hash), m_tuser (length mismatch)
// cfg_*     in         cfg_wr_en          cfg_addr, cfg_wdata
//
// one item per cycle enters while the queue has room; the back end updates the hash for each item
// through its single 32x32 multiplier, taking a new item only in its run state
// the last item starts the avalanche there: ST_M0 (mode 0) or ST_M1 to ST_M4 (mode 1)
// front premix pipeline registers s1 and s2, then the queue, then the result register
// synchronous reset clears control state only; no clearing pass
// either side may stall independently, the queue absorbs the difference
module murmur2_stream_hasher #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [0:0]                       cfg_addr,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // data_word[31:0], byte_count[34:32], msg_length[65:35], zero fill
  input  logic [mm2_pkg::IN_TDATA_W-1:0]   s_tdata,
  // last_item
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // hash_value[63:0]
  output logic [63:0]                      m_tdata,
  // length_mismatch[0]
  output logic [0:0]                       m_tuser
);
  import mm2_pkg::*;

  localparam logic [0:0] REG_SEED = 1'b0;
  localparam logic [0:0] REG_MODE = 1'b1;

  logic [31:0] seed;
  logic        hash_mode;
  logic        f_valid;
  logic        f_ready;
  item_t       f_item;
  logic        q_valid;
  logic        q_ready;
  item_t       q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= 32'd0;
      hash_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SEED: seed      <= cfg_wdata;
        REG_MODE: hash_mode <= cfg_wdata[0];
        default:  seed      <= seed;
      endcase
    end
  end

  mm2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .hash_mode  (hash_mode),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  mm2_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_item)
  );

  mm2_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
